/* rtl/core/register_alu_instruction_executor_top_macros.svh */
// Assertion macros shared by the checker files of the instruction executor.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef REGISTER_ALU_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH
`define REGISTER_ALU_INSTRUCTION_EXECUTOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAIE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/raie_pkg.sv */
// Shared types, codes and field layout of the register ALU instruction executor.
// Used by the top level, the checker and the bench; depends on nothing.
package raie_pkg;

    localparam int MEM_WORDS_DEF   = 256;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int NUM_REGS        = 5;
    localparam int REG_AW          = 3;
    localparam int DATA_W          = 10;
    localparam int CALC_W          = 12;

    // Request and result bus widths.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // Request field positions, lowest field first.
    localparam int IN_CMD_LSB   = 0;
    localparam int IN_SK_LSB    = 4;
    localparam int IN_DK_LSB    = 6;
    localparam int IN_SR_LSB    = 8;
    localparam int IN_DR_LSB    = 11;
    localparam int IN_IMM_LSB   = 14;
    localparam int IN_MADDR_LSB = 22;

    localparam logic [3:0] CMD_ADD  = 4'd0;
    localparam logic [3:0] CMD_SUB  = 4'd1;
    localparam logic [3:0] CMD_AND  = 4'd2;
    localparam logic [3:0] CMD_OR   = 4'd3;
    localparam logic [3:0] CMD_XOR  = 4'd4;
    localparam logic [3:0] CMD_NOT  = 4'd5;
    localparam logic [3:0] CMD_INC  = 4'd6;
    localparam logic [3:0] CMD_MOV  = 4'd7;
    localparam logic [3:0] CMD_PUSH = 4'd8;
    localparam logic [3:0] CMD_POP  = 4'd9;

    localparam logic [1:0] SRC_REG     = 2'd0;
    localparam logic [1:0] SRC_IMM     = 2'd1;
    localparam logic [1:0] SRC_MEM_DIR = 2'd2;
    localparam logic [1:0] SRC_MEM_IND = 2'd3;

    localparam logic [1:0] DST_REG     = 2'd0;
    localparam logic [1:0] DST_MEM_DIR = 2'd1;
    localparam logic [1:0] DST_MEM_IND = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_INVALID   = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd2;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_MEMRD = 4'b1000
    } state_t;

    // Wraps a raw result once by 256 and keeps the low ten bits.
    function automatic logic [DATA_W-1:0] wrap10(input logic signed [CALC_W-1:0] v);
        logic signed [CALC_W-1:0] w;
        begin
            if (v > 12'sd256)
            begin
                w = v - 12'sd256;
            end
            else if (v < 12'sd0)
            begin
                w = v + 12'sd256;
            end
            else
            begin
                w = v;
            end
            return w[DATA_W-1:0];
        end
    endfunction

    // Sign-extends a stored ten-bit word to the arithmetic width.
    function automatic logic signed [CALC_W-1:0] sext(input logic [DATA_W-1:0] d);
        return signed'({{(CALC_W-DATA_W){d[DATA_W-1]}}, d});
    endfunction

endpackage

/* rtl/core/raie_ram.sv */
// Generic synchronous RAM: one write port and two read ports with registered data.
// Depends on nothing; width and depth come from parameters.
module raie_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
        end
        if (re_b)
        begin
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* rtl/core/register_alu_instruction_executor_top.sv */
// Register ALU instruction executor: five registers, flags, data memory and a data stack.
// A request is taken in IDLE and its result is registered in EXEC, or in MEMRD for a move
// from register-indirect memory; the finish waits while the result register is full. A new
// request is taken only once the previous one has finished, including any data memory read.
// Reset: async, active low; then a clearing pass over all of data memory zeroes it and
// the register file, during which no request is taken. Uses raie_pkg and raie_ram.
module register_alu_instruction_executor_top #(
    parameter int MEM_WORDS   = raie_pkg::MEM_WORDS_DEF,
    parameter int STACK_DEPTH = raie_pkg::STACK_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata from bit 0: cmd[4], src_kind[2], dst_kind[2], src_reg[3], dst_reg[3],
    // immediate[8], mem_addr[8], zero fill[2].
    input  logic [raie_pkg::S_TDATA_W-1:0]  s_tdata,
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata from bit 0: status[2], written_value[10] (signed), carry_flag[1],
    // zero_flag[1], zero fill[2].
    output logic [raie_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int DW     = raie_pkg::DATA_W;
    localparam int CW     = raie_pkg::CALC_W;
    localparam int RAW    = raie_pkg::REG_AW;

    // ------------------------------------------------------------------
    // Control state. The block works on one request at a time: a request
    // is taken in IDLE, where the register file, the direct memory address
    // and the top of stack are all read. EXEC sees that read data and
    // either finishes or, for a load through a register, reads data memory
    // once more and finishes in MEMRD. Every write to the memories by a request
    // happens in the finishing cycle, so the next request, which is read no
    // earlier than the following cycle, always sees the updated contents.
    // ------------------------------------------------------------------
    raie_pkg::state_t state_reg;
    raie_pkg::state_t state_next;

    logic [MEM_AW-1:0] clr_idx_reg;

    // Latched request fields.
    logic [3:0] cmd_reg;
    logic [1:0] sk_reg;
    logic [1:0] dk_reg;
    logic [2:0] sr_reg;
    logic [2:0] dr_reg;
    logic [7:0] imm_reg;
    logic [7:0] maddr_reg;

    // Architectural state held in flip-flops.
    logic             carry_reg;
    logic             zero_reg;
    logic [CNT_W-1:0] stk_cnt_reg;
    logic [CNT_W-1:0] stk_cnt_next;
    // Register A is read by every add and subtract next to two register
    // operands, so a copy of it is kept outside the register file.
    logic [DW-1:0]    a_copy_reg;

    // Result register that parts the two sides of the block.
    logic                           m_tvalid_reg;
    logic [raie_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // Memory ports.
    logic            rf_we;
    logic [RAW-1:0]  rf_waddr;
    logic [DW-1:0]   rf_wdata;
    logic [DW-1:0]   rf_rdata_src;
    logic [DW-1:0]   rf_rdata_dst;
    logic            dm_we;
    logic [MEM_AW-1:0] dm_waddr;
    logic [DW-1:0]   dm_wdata;
    logic [DW-1:0]   dm_rdata_dir;
    logic [DW-1:0]   dm_rdata_ind;
    logic            dm_re_ind;
    logic            stk_we;
    logic [DW-1:0]   stk_rdata;

    logic accept;
    logic finish;
    logic need_indirect;

    // Results of the execute logic.
    logic [1:0]    res_status;
    logic [DW-1:0] res_wv;
    logic          res_carry;
    logic          res_zero;
    logic          res_reg_we;
    logic          res_mem_we;
    logic [MEM_AW-1:0] res_mem_addr;
    logic          res_push;
    logic          res_pop;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == raie_pkg::ST_IDLE);

    // A load through a register needs the register value as a memory
    // address, so it takes one extra memory read after EXEC.
    assign need_indirect = (cmd_reg == raie_pkg::CMD_MOV) &&
                           (sk_reg == raie_pkg::SRC_MEM_IND) &&
                           (dk_reg == raie_pkg::DST_REG) &&
                           (sr_reg < 3'(raie_pkg::NUM_REGS)) &&
                           (dr_reg < 3'(raie_pkg::NUM_REGS));

    // The result is committed only when the output register is free or
    // being emptied in this cycle; otherwise the block waits with all
    // read data held in the memories' output registers.
    assign finish = ((state_reg == raie_pkg::ST_EXEC && !need_indirect) ||
                     (state_reg == raie_pkg::ST_MEMRD)) &&
                    (!m_tvalid_reg || m_tready);

    assign dm_re_ind = (state_reg == raie_pkg::ST_EXEC) && need_indirect;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            raie_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == MEM_AW'(MEM_WORDS - 1))
                begin
                    state_next = raie_pkg::ST_IDLE;
                end
            end
            raie_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = raie_pkg::ST_EXEC;
                end
            end
            raie_pkg::ST_EXEC:
            begin
                if (need_indirect)
                begin
                    state_next = raie_pkg::ST_MEMRD;
                end
                else if (finish)
                begin
                    state_next = raie_pkg::ST_IDLE;
                end
            end
            raie_pkg::ST_MEMRD:
            begin
                if (finish)
                begin
                    state_next = raie_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = raie_pkg::ST_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Execute logic. All operands are widened to twelve signed bits, which
    // holds every sum, difference and complement of two ten-bit words, so
    // the flags are taken from the exact unwrapped value.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [CW-1:0] src_x;
        logic signed [CW-1:0] dst_x;
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] imm_x;
        logic signed [CW-1:0] opnd_x;
        logic signed [CW-1:0] mem_x;
        logic signed [CW-1:0] v;
        logic                 sr_ok;
        logic                 dr_ok;
        logic                 dir_ok;
        logic                 ind_src_ok;
        logic                 ind_dst_ok;
        logic                 set_fl;

        src_x      = raie_pkg::sext(rf_rdata_src);
        dst_x      = raie_pkg::sext(rf_rdata_dst);
        a_x        = raie_pkg::sext(a_copy_reg);
        imm_x      = signed'({4'b0000, imm_reg});
        opnd_x     = (sk_reg == raie_pkg::SRC_IMM) ? imm_x : src_x;
        sr_ok      = (sr_reg < 3'(raie_pkg::NUM_REGS));
        dr_ok      = (dr_reg < 3'(raie_pkg::NUM_REGS));
        dir_ok     = ({1'b0, maddr_reg} < 9'(MEM_WORDS));
        ind_src_ok = !rf_rdata_src[DW-1] && (rf_rdata_src < DW'(MEM_WORDS));
        ind_dst_ok = !rf_rdata_dst[DW-1] && (rf_rdata_dst < DW'(MEM_WORDS));

        // An address outside data memory reads as zero.
        if (sk_reg == raie_pkg::SRC_MEM_DIR)
        begin
            mem_x = dir_ok ? raie_pkg::sext(dm_rdata_dir) : '0;
        end
        else
        begin
            mem_x = ind_src_ok ? raie_pkg::sext(dm_rdata_ind) : '0;
        end

        res_status   = raie_pkg::STAT_OK;
        res_wv       = '0;
        res_carry    = carry_reg;
        res_zero     = zero_reg;
        res_reg_we   = 1'b0;
        res_mem_we   = 1'b0;
        res_mem_addr = maddr_reg[MEM_AW-1:0];
        res_push     = 1'b0;
        res_pop      = 1'b0;
        set_fl       = 1'b0;
        v            = '0;

        unique case (cmd_reg) inside
            raie_pkg::CMD_ADD, raie_pkg::CMD_SUB, raie_pkg::CMD_AND,
            raie_pkg::CMD_OR, raie_pkg::CMD_XOR, raie_pkg::CMD_NOT:
            begin
                if (dk_reg != raie_pkg::DST_REG || !dr_ok || sk_reg > raie_pkg::SRC_IMM ||
                    (sk_reg == raie_pkg::SRC_REG && !sr_ok))
                begin
                    res_status = raie_pkg::STAT_INVALID;
                end
                else
                begin
                    case (cmd_reg)
                        raie_pkg::CMD_ADD: v = a_x + opnd_x;
                        raie_pkg::CMD_SUB: v = a_x - opnd_x;
                        raie_pkg::CMD_AND: v = opnd_x & dst_x;
                        raie_pkg::CMD_OR:  v = opnd_x | dst_x;
                        raie_pkg::CMD_XOR: v = opnd_x ^ dst_x;
                        default:           v = ~opnd_x;
                    endcase
                    res_reg_we = 1'b1;
                    set_fl     = 1'b1;
                end
            end
            raie_pkg::CMD_INC:
            begin
                if (sk_reg != raie_pkg::SRC_REG || dk_reg != raie_pkg::DST_REG ||
                    !sr_ok || !dr_ok)
                begin
                    res_status = raie_pkg::STAT_INVALID;
                end
                else
                begin
                    v          = src_x + 12'sd1;
                    res_reg_we = 1'b1;
                    set_fl     = 1'b1;
                end
            end
            raie_pkg::CMD_MOV:
            begin
                if (sk_reg == raie_pkg::SRC_MEM_DIR || sk_reg == raie_pkg::SRC_MEM_IND)
                begin
                    // Loads go to a register only.
                    if (dk_reg != raie_pkg::DST_REG || !dr_ok ||
                        (sk_reg == raie_pkg::SRC_MEM_IND && !sr_ok))
                    begin
                        res_status = raie_pkg::STAT_INVALID;
                    end
                    else
                    begin
                        v          = mem_x;
                        res_reg_we = 1'b1;
                        set_fl     = 1'b1;
                    end
                end
                else if ((sk_reg == raie_pkg::SRC_REG && !sr_ok) ||
                         (dk_reg != raie_pkg::DST_REG && dk_reg != raie_pkg::DST_MEM_DIR &&
                          dk_reg != raie_pkg::DST_MEM_IND) ||
                         (dk_reg != raie_pkg::DST_MEM_DIR && !dr_ok))
                begin
                    res_status = raie_pkg::STAT_INVALID;
                end
                else if (dk_reg == raie_pkg::DST_REG)
                begin
                    v          = opnd_x;
                    res_reg_we = 1'b1;
                    set_fl     = 1'b1;
                end
                else
                begin
                    // A store keeps the value unwrapped and leaves the flags alone.
                    // Out-of-range addresses drop the write but still report it.
                    res_wv = opnd_x[DW-1:0];
                    if (dk_reg == raie_pkg::DST_MEM_DIR)
                    begin
                        res_mem_we   = dir_ok;
                        res_mem_addr = maddr_reg[MEM_AW-1:0];
                    end
                    else
                    begin
                        res_mem_we   = ind_dst_ok;
                        res_mem_addr = rf_rdata_dst[MEM_AW-1:0];
                    end
                end
            end
            raie_pkg::CMD_PUSH:
            begin
                // Flags follow the immediate even when the stack is full.
                v      = imm_x;
                set_fl = 1'b1;
                if (stk_cnt_reg >= CNT_W'(STACK_DEPTH))
                begin
                    res_status = raie_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    res_push = 1'b1;
                    res_wv   = raie_pkg::wrap10(imm_x);
                end
            end
            raie_pkg::CMD_POP:
            begin
                if (!dr_ok)
                begin
                    res_status = raie_pkg::STAT_INVALID;
                end
                else if (stk_cnt_reg == '0)
                begin
                    res_status = raie_pkg::STAT_UNDERFLOW;
                end
                else
                begin
                    v          = raie_pkg::sext(stk_rdata);
                    res_pop    = 1'b1;
                    res_reg_we = 1'b1;
                    set_fl     = 1'b1;
                end
            end
            default:
            begin
                res_status = raie_pkg::STAT_INVALID;
            end
        endcase

        if (res_reg_we)
        begin
            res_wv = raie_pkg::wrap10(v);
        end
        if (set_fl)
        begin
            res_carry = (v < 12'sd0) || (v > 12'sd256);
            res_zero  = (v == 12'sd0);
        end
    end

    always_comb
    begin
        stk_cnt_next = stk_cnt_reg;
        if (finish && res_push)
        begin
            stk_cnt_next = stk_cnt_reg + 1'b1;
        end
        else if (finish && res_pop)
        begin
            stk_cnt_next = stk_cnt_reg - 1'b1;
        end
    end

    // Memory write ports: the clearing pass owns them right after reset.
    always_comb
    begin
        if (state_reg == raie_pkg::ST_CLEAR)
        begin
            rf_we    = (clr_idx_reg < MEM_AW'(raie_pkg::NUM_REGS));
            rf_waddr = clr_idx_reg[RAW-1:0];
            rf_wdata = '0;
            dm_we    = 1'b1;
            dm_waddr = clr_idx_reg;
            dm_wdata = '0;
        end
        else
        begin
            rf_we    = finish && res_reg_we;
            rf_waddr = dr_reg;
            rf_wdata = res_wv;
            dm_we    = finish && res_mem_we;
            dm_waddr = res_mem_addr;
            dm_wdata = res_wv;
        end
    end

    assign stk_we = finish && res_push;

    // Register file: port a reads the source register, port b the
    // destination (or address) register.
    raie_ram #(
        .WIDTH (DW),
        .DEPTH (raie_pkg::NUM_REGS)
    ) u_reg_ram (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .re_a    (accept),
        .raddr_a (s_tdata[raie_pkg::IN_SR_LSB +: RAW]),
        .rdata_a (rf_rdata_src),
        .re_b    (accept),
        .raddr_b (s_tdata[raie_pkg::IN_DR_LSB +: RAW]),
        .rdata_b (rf_rdata_dst)
    );

    // Data memory: port a reads the direct address as the request arrives,
    // port b reads through a register in EXEC.
    raie_ram #(
        .WIDTH (DW),
        .DEPTH (MEM_WORDS)
    ) u_data_ram (
        .clk     (clk),
        .we      (dm_we),
        .waddr   (dm_waddr),
        .wdata   (dm_wdata),
        .re_a    (accept),
        .raddr_a (s_tdata[raie_pkg::IN_MADDR_LSB +: MEM_AW]),
        .rdata_a (dm_rdata_dir),
        .re_b    (dm_re_ind),
        .raddr_b (rf_rdata_src[MEM_AW-1:0]),
        .rdata_b (dm_rdata_ind)
    );

    // Data stack: the top entry is read as each request arrives, so a pop
    // has its value in EXEC. Entries above the count are never used.
    raie_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .we      (stk_we),
        .waddr   (stk_cnt_reg[STK_AW-1:0]),
        .wdata   (res_wv),
        .re_a    (accept),
        .raddr_a (STK_AW'(stk_cnt_reg - 1'b1)),
        .rdata_a (stk_rdata),
        .re_b    (1'b0),
        .raddr_b ('0),
        .rdata_b ()
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= raie_pkg::ST_CLEAR;
            clr_idx_reg  <= '0;
            carry_reg    <= 1'b0;
            zero_reg     <= 1'b0;
            stk_cnt_reg  <= '0;
            a_copy_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            stk_cnt_reg <= stk_cnt_next;
            if (state_reg == raie_pkg::ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (finish)
            begin
                carry_reg    <= res_carry;
                zero_reg     <= res_zero;
                m_tvalid_reg <= 1'b1;
                if (res_reg_we && dr_reg == '0)
                begin
                    a_copy_reg <= res_wv;
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_tdata[raie_pkg::IN_CMD_LSB +: 4];
            sk_reg    <= s_tdata[raie_pkg::IN_SK_LSB +: 2];
            dk_reg    <= s_tdata[raie_pkg::IN_DK_LSB +: 2];
            sr_reg    <= s_tdata[raie_pkg::IN_SR_LSB +: 3];
            dr_reg    <= s_tdata[raie_pkg::IN_DR_LSB +: 3];
            imm_reg   <= s_tdata[raie_pkg::IN_IMM_LSB +: 8];
            maddr_reg <= s_tdata[raie_pkg::IN_MADDR_LSB +: 8];
        end
        if (finish)
        begin
            m_tdata_reg <= {2'b00, res_zero, res_carry, res_wv, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/core/raie_checker.sv */
// Port-level checker for the register ALU instruction executor, bound to the top level.
// Depends on raie_pkg and the assertion macros header.
`include "register_alu_instruction_executor_top_macros.svh"

module raie_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [raie_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [1:0] status;
    logic [9:0] wv;
    logic       carry;
    logic       zero;
    logic       s_fire;

    assign status = m_tdata[1:0];
    assign wv     = m_tdata[11:2];
    assign carry  = m_tdata[12];
    assign zero   = m_tdata[13];
    assign s_fire = s_tvalid && s_tready;

    // A stalled result holds.
    `RAIE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Any failing status writes nothing.
    `RAIE_ASSERT_SAME(a_fail_zero, m_tvalid && status != raie_pkg::STAT_OK, wv == 10'd0, "failed request reports a written value")

    // Written values stay within minus one to 256.
    `RAIE_ASSERT_SAME(a_wv_range, m_tvalid, wv == 10'h3FF || wv <= 10'd256, "written value out of range")

    // Carry and zero are taken from the same value and never both set.
    `RAIE_ASSERT_SAME(a_flags_excl, m_tvalid, !(carry && zero), "carry and zero both set")

    // Requests are executed one at a time.
    `RAIE_ASSERT_NEXT(a_one_at_a_time, s_fire, !s_tready, "request taken while another executes")

endmodule

bind register_alu_instruction_executor_top raie_checker u_raie_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for register_alu_instruction_executor_top: random and directed instructions
// are checked against an in-bench prediction of registers, flags, memory and stack.
// Depends on raie_pkg and the executor RTL only.
module tb;

    import raie_pkg::*;

    // Register indexes and codes that the package leaves unnamed.
    localparam logic [2:0] REG_A   = 3'd0;
    localparam logic [2:0] REG_B   = 3'd1;
    localparam logic [2:0] REG_C   = 3'd2;
    localparam logic [2:0] REG_D   = 3'd3;
    localparam logic [2:0] REG_E   = 3'd4;
    localparam logic [2:0] REG_BAD = 3'd7;
    localparam logic [3:0] CMD_UNDEF = 4'd15;
    localparam logic [1:0] DST_BAD   = 2'd3;

    // Result word layout, lowest field first.
    localparam int OUT_ST_LSB = 0;
    localparam int OUT_WV_LSB = 2;
    localparam int OUT_CY_BIT = 12;
    localparam int OUT_ZF_BIT = 13;

    localparam int WRAP_AT      = 256;
    localparam int RANDOM_ITEMS = 900;
    localparam int IDLE_PCT     = 34;
    localparam int SETTLE_CYC   = 12;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] value;
        logic              carry;
        logic              zero;
    } exec_result_t;

    // Tracks the machine state as the executor should see it and holds the results
    // that accepted requests still owe, oldest first.
    class exec_tracker;
        int regs[NUM_REGS];
        int dmem[MEM_WORDS_DEF];
        int stk_words[STACK_DEPTH_DEF];
        int depth;
        bit carry;
        bit zero;
        exec_result_t predicted_results[$];
        int errors;
        int checked;
        int status_seen[4];

        function int trim10(int v);
            logic signed [DATA_W-1:0] t;
            t = v[DATA_W-1:0];
            return int'(t);
        endfunction

        // A single correction by 256 toward the range 0..256.
        function int fold(int v);
            if (v > WRAP_AT)
                return v - WRAP_AT;
            if (v < 0)
                return v + WRAP_AT;
            return v;
        endfunction

        function void take_flags(int raw);
            carry = (raw < 0) || (raw > WRAP_AT);
            zero  = (raw == 0);
        endfunction

        function int write_reg(logic [2:0] idx, int raw);
            int wv;
            wv = trim10(fold(raw));
            regs[idx] = wv;
            take_flags(raw);
            return wv;
        endfunction

        function bit addr_hit(int a);
            return (a >= 0) && (a < MEM_WORDS_DEF);
        endfunction

        function int mem_peek(int a);
            return addr_hit(a) ? dmem[a] : 0;
        endfunction

        function int outstanding();
            return predicted_results.size();
        endfunction

        // Executes one accepted request on the tracked state and queues its result.
        function void note_request(logic [S_TDATA_W-1:0] word);
            logic [3:0]   op;
            logic [1:0]   sk;
            logic [1:0]   dk;
            logic [2:0]   sr;
            logic [2:0]   dr;
            int           imm;
            int           maddr;
            bit           sr_ok;
            bit           dr_ok;
            int           opnd;
            int           raw;
            int           addr;
            exec_result_t res;
            op    = word[IN_CMD_LSB +: 4];
            sk    = word[IN_SK_LSB +: 2];
            dk    = word[IN_DK_LSB +: 2];
            sr    = word[IN_SR_LSB +: 3];
            dr    = word[IN_DR_LSB +: 3];
            imm   = int'(word[IN_IMM_LSB +: 8]);
            maddr = int'(word[IN_MADDR_LSB +: 8]);
            sr_ok = sr < NUM_REGS;
            dr_ok = dr < NUM_REGS;
            res.status = STAT_OK;
            raw = 0;
            opnd = 0;
            addr = 0;
            // Written value stays zero unless something is written.
            res.value = '0;
            if (op <= CMD_NOT)
            begin
                if (dk != DST_REG || !dr_ok || sk > SRC_IMM || (sk == SRC_REG && !sr_ok))
                begin
                    res.status = STAT_INVALID;
                end
                else
                begin
                    opnd = (sk == SRC_IMM) ? imm : regs[sr];
                    case (op)
                        CMD_ADD: raw = regs[REG_A] + opnd;
                        CMD_SUB: raw = regs[REG_A] - opnd;
                        CMD_AND: raw = opnd & regs[dr];
                        CMD_OR:  raw = opnd | regs[dr];
                        CMD_XOR: raw = opnd ^ regs[dr];
                        default: raw = ~opnd;
                    endcase
                    res.value = DATA_W'(write_reg(dr, raw));
                end
            end
            else if (op == CMD_INC)
            begin
                if (sk != SRC_REG || dk != DST_REG || !sr_ok || !dr_ok)
                    res.status = STAT_INVALID;
                else
                    res.value = DATA_W'(write_reg(dr, regs[sr] + 1));
            end
            else if (op == CMD_MOV)
            begin
                if (sk == SRC_MEM_DIR || sk == SRC_MEM_IND)
                begin
                    // Loads from memory may only land in a register.
                    if (dk != DST_REG || !dr_ok || (sk == SRC_MEM_IND && !sr_ok))
                        res.status = STAT_INVALID;
                    else
                        res.value = DATA_W'(write_reg(dr,
                            mem_peek(sk == SRC_MEM_DIR ? maddr : regs[sr])));
                end
                else if ((sk == SRC_REG && !sr_ok) || dk > DST_MEM_IND
                         || (dk != DST_MEM_DIR && !dr_ok))
                begin
                    res.status = STAT_INVALID;
                end
                else
                begin
                    opnd = (sk == SRC_IMM) ? imm : regs[sr];
                    if (dk == DST_REG)
                    begin
                        res.value = DATA_W'(write_reg(dr, opnd));
                    end
                    else
                    begin
                        // Stores keep the value unwrapped and leave the flags alone;
                        // an address outside memory drops the write.
                        res.value = DATA_W'(trim10(opnd));
                        addr = (dk == DST_MEM_DIR) ? maddr : regs[dr];
                        if (addr_hit(addr))
                            dmem[addr] = trim10(opnd);
                    end
                end
            end
            else if (op == CMD_PUSH)
            begin
                if (depth >= STACK_DEPTH_DEF)
                begin
                    res.status = STAT_OVERFLOW;
                end
                else
                begin
                    res.value = DATA_W'(trim10(fold(imm)));
                    stk_words[depth] = trim10(fold(imm));
                    depth++;
                end
                // Flags follow the immediate even when the stack is full.
                take_flags(imm);
            end
            else if (op == CMD_POP)
            begin
                if (!dr_ok)
                begin
                    res.status = STAT_INVALID;
                end
                else if (depth == 0)
                begin
                    res.status = STAT_UNDERFLOW;
                end
                else
                begin
                    depth--;
                    res.value = DATA_W'(write_reg(dr, stk_words[depth]));
                end
            end
            else
            begin
                res.status = STAT_INVALID;
            end
            res.carry = carry;
            res.zero  = zero;
            predicted_results.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] word);
            exec_result_t want;
            logic [1:0]        st;
            logic [DATA_W-1:0] wv;
            logic              cy;
            logic              zf;
            st = word[OUT_ST_LSB +: 2];
            wv = word[OUT_WV_LSB +: DATA_W];
            cy = word[OUT_CY_BIT];
            zf = word[OUT_ZF_BIT];
            checked++;
            if (predicted_results.size() == 0)
            begin
                report_mismatch($sformatf("result %h arrived with no request pending", word));
                return;
            end
            want = predicted_results.pop_front();
            status_seen[want.status]++;
            if (st != want.status || wv != want.value || cy != want.carry || zf != want.zero)
                report_mismatch($sformatf(
                    "result %0d: status %0d value %0d c%0b z%0b, expected %0d value %0d c%0b z%0b",
                    checked, st, $signed(wv), cy, zf,
                    want.status, $signed(want.value), want.carry, want.zero));
        endtask

        task finish_check();
            if (predicted_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          predicted_results.size()));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    exec_tracker tracker;
    // While calm is set neither side inserts bubbles.
    bit calm = 1'b0;
    int items;

    register_alu_instruction_executor_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    // The run normally takes a small fraction of this; reaching it means a hang.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [S_TDATA_W-1:0] pack_req(
        input logic [3:0] op,
        input logic [1:0] sk,
        input logic [1:0] dk,
        input logic [2:0] sr,
        input logic [2:0] dr,
        input logic [7:0] imm,
        input logic [7:0] maddr
    );
        logic [S_TDATA_W-1:0] w;
        w = '0;
        w[IN_CMD_LSB +: 4]   = op;
        w[IN_SK_LSB +: 2]    = sk;
        w[IN_DK_LSB +: 2]    = dk;
        w[IN_SR_LSB +: 3]    = sr;
        w[IN_DR_LSB +: 3]    = dr;
        w[IN_IMM_LSB +: 8]   = imm;
        w[IN_MADDR_LSB +: 8] = maddr;
        return w;
    endfunction

    // Byte values lean toward both ends of the range.
    function automatic logic [7:0] any_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'h00;
        if (r < 30)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Direct addresses mostly fall in a small window so that loads find earlier stores.
    function automatic logic [7:0] near_addr();
        if ($urandom_range(0, 99) < 60)
            return 8'($urandom_range(0, 15));
        return any_byte();
    endfunction

    // A legal instruction with random operands.
    function automatic logic [S_TDATA_W-1:0] legal_instruction();
        logic [3:0] op;
        logic [1:0] sk;
        logic [1:0] dk;
        op = 4'($urandom_range(CMD_ADD, CMD_POP));
        sk = 2'($urandom_range(SRC_REG, SRC_MEM_IND));
        dk = 2'($urandom_range(DST_REG, DST_MEM_IND));
        if (op <= CMD_NOT)
        begin
            sk = 2'($urandom_range(SRC_REG, SRC_IMM));
            dk = DST_REG;
        end
        else if (op == CMD_INC)
        begin
            sk = SRC_REG;
            dk = DST_REG;
        end
        else if (op == CMD_MOV && sk >= SRC_MEM_DIR)
        begin
            dk = DST_REG;
        end
        return pack_req(op, sk, dk, 3'($urandom_range(REG_A, REG_E)),
                        3'($urandom_range(REG_A, REG_E)), any_byte(), near_addr());
    endfunction

    // Offers one request and returns once it has been taken. Valid stays high after
    // acceptance so that back-to-back requests need no extra edge.
    task automatic send_req(input logic [S_TDATA_W-1:0] word);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (!calm && $urandom_range(0, 99) < IDLE_PCT);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_request(word);
        items++;
    endtask

    // Holds the request side quiet until every outstanding result is back.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.outstanding() != 0);
    endtask

    // Result side: checks every accepted result and stalls at random.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        int mode;
        int burst;
        int guard;
        int target;
        tracker = new;
        items = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Requests wait out the clearing pass through the handshake.
        // A full byte stored at the top address and read back into C.
        send_req(pack_req(CMD_MOV, SRC_IMM, DST_MEM_DIR, REG_A, REG_A, 8'hFF, 8'hFF));
        send_req(pack_req(CMD_MOV, SRC_MEM_DIR, DST_REG, REG_A, REG_C, 8'h00, 8'hFF));
        // A reaches 256, the top value that needs no wrap; INC then wraps with carry.
        send_req(pack_req(CMD_MOV, SRC_IMM, DST_REG, REG_A, REG_A, 8'h01, 8'h00));
        send_req(pack_req(CMD_ADD, SRC_IMM, DST_REG, REG_A, REG_A, 8'hFF, 8'h00));
        send_req(pack_req(CMD_INC, SRC_REG, DST_REG, REG_A, REG_D, 8'h00, 8'h00));
        // Indirect access through A = 256 lies past the memory: store dropped, load gives 0.
        send_req(pack_req(CMD_MOV, SRC_REG, DST_MEM_IND, REG_A, REG_A, 8'h00, 8'h00));
        send_req(pack_req(CMD_MOV, SRC_MEM_IND, DST_REG, REG_A, REG_E, 8'h00, 8'h00));
        // NOT of 256 wraps to -1, an address below the memory.
        send_req(pack_req(CMD_NOT, SRC_REG, DST_REG, REG_A, REG_B, 8'h00, 8'h00));
        send_req(pack_req(CMD_MOV, SRC_IMM, DST_MEM_IND, REG_A, REG_B, 8'h55, 8'h00));
        // Register-indirect store and load through D = 1.
        send_req(pack_req(CMD_MOV, SRC_REG, DST_MEM_IND, REG_C, REG_D, 8'h00, 8'h00));
        send_req(pack_req(CMD_MOV, SRC_MEM_IND, DST_REG, REG_D, REG_B, 8'h00, 8'h00));
        // Subtraction down to exactly zero, then below zero with carry.
        send_req(pack_req(CMD_SUB, SRC_REG, DST_REG, REG_B, REG_A, 8'h00, 8'h00));
        send_req(pack_req(CMD_SUB, SRC_IMM, DST_REG, REG_A, REG_A, 8'h01, 8'h00));
        send_req(pack_req(CMD_SUB, SRC_IMM, DST_REG, REG_A, REG_A, 8'hFF, 8'h00));
        send_req(pack_req(CMD_AND, SRC_IMM, DST_REG, REG_A, REG_C, 8'hF0, 8'h00));
        send_req(pack_req(CMD_OR,  SRC_REG, DST_REG, REG_B, REG_C, 8'h00, 8'h00));
        send_req(pack_req(CMD_XOR, SRC_IMM, DST_REG, REG_A, REG_C, 8'hFF, 8'h00));
        send_req(pack_req(CMD_NOT, SRC_IMM, DST_REG, REG_A, REG_E, 8'hFF, 8'h00));
        // One push, two pops: the second pop finds the stack empty.
        send_req(pack_req(CMD_PUSH, SRC_REG, DST_REG, REG_A, REG_A, 8'h00, 8'h00));
        send_req(pack_req(CMD_POP, SRC_REG, DST_REG, REG_A, REG_A, 8'h00, 8'h00));
        send_req(pack_req(CMD_POP, SRC_REG, DST_REG, REG_A, REG_B, 8'h00, 8'h00));
        // Illegal forms: unknown command, bad destination kind, bad register index.
        send_req(pack_req(CMD_UNDEF, SRC_REG, DST_REG, REG_A, REG_A, 8'h00, 8'h00));
        send_req(pack_req(CMD_ADD, SRC_REG, DST_BAD, REG_BAD, REG_A, 8'h00, 8'h00));
        send_req(pack_req(CMD_POP, SRC_REG, DST_REG, REG_A, REG_BAD, 8'h00, 8'h00));
        hold_until_drained();

        // Random part: mostly legal instructions, stack bursts long enough to hit both
        // full and empty, and some requests with every field random.
        target = items + RANDOM_ITEMS;
        while (items < target)
        begin
            calm = (items >= target - 500) && (items < target - 340);
            mode = $urandom_range(0, 99);
            if (mode < 8)
            begin
                send_req(pack_req(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                                  2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                  3'($urandom_range(0, 7)), any_byte(),
                                  8'($urandom_range(0, 255))));
            end
            else if (mode < 14)
            begin
                burst = $urandom_range(1, STACK_DEPTH_DEF + 4);
                repeat (burst)
                    send_req(pack_req(mode < 11 ? CMD_PUSH : CMD_POP,
                                      2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                      3'($urandom_range(0, 7)),
                                      3'($urandom_range(REG_A, REG_E)),
                                      any_byte(), 8'($urandom_range(0, 255))));
            end
            else
            begin
                send_req(legal_instruction());
            end
            if ($urandom_range(0, 99) == 0)
                hold_until_drained();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Wait for the tail of results, then let the bench settle to catch anything unexpected.
        guard = 0;
        while (tracker.outstanding() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYC)
            @(posedge clk);
        tracker.finish_check();

        $display("Sent %0d instructions, checked %0d results.", items, tracker.checked);
        $display("Status mix: ok %0d, invalid %0d, overflow %0d, underflow %0d.",
                 tracker.status_seen[STAT_OK], tracker.status_seen[STAT_INVALID],
                 tracker.status_seen[STAT_OVERFLOW], tracker.status_seen[STAT_UNDERFLOW]);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/raie_pkg.sv
rtl/core/raie_ram.sv
rtl/core/register_alu_instruction_executor_top.sv
rtl/core/raie_checker.sv
tb/sv/tb.sv
